FILE: design/ccmt_pkg.sv
// shared types, constants and functions for the character context model trainer
package ccmt_pkg;

  localparam int TableEntries = 4096;
  localparam int MaxContext = 4;
  localparam int AddrW = $clog2(TableEntries);
  localparam int CountW = $clog2(TableEntries + 1);
  localparam int LenW = $clog2(MaxContext + 1);
  localparam int WeightW = 15;
  localparam int KeyW = LenW + 8 * MaxContext + 8;
  localparam int EntryW = KeyW + WeightW;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW = $clog2(QueueDepth);

  localparam logic [WeightW-1:0] NewWeight = WeightW'(256);
  localparam logic [WeightW-1:0] CeilingReset = WeightW'(25600);

  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic [8*MaxContext-1:0] history;
    logic [LenW-1:0] depth;
  } job_t;

  typedef struct packed {
    logic valid;
    logic [2:0] created;
    logic [2:0] dropped;
    logic [CountW-1:0] entries;
    logic [4*WeightW-1:0] weights;
  } report_t;

  // key of the pair with context length len: unused context bytes masked to zero
  function automatic key_t make_key(input logic [LenW-1:0] len,
                                    input logic [8*MaxContext-1:0] hist,
                                    input logic [7:0] next_byte);
    logic [8*MaxContext-1:0] masked;
    masked = '0;
    for (int k = 0; k < MaxContext; k++) begin
      if (LenW'(k) < len) masked[8*k +: 8] = hist[8*k +: 8];
    end
    return {len, masked, next_byte};
  endfunction

  // signed gap truncated toward zero, divided by fifty
  function automatic logic [WeightW-1:0] smooth(input logic [WeightW-1:0] cur,
                                                input logic [WeightW-1:0] ceil);
    logic signed [WeightW+1:0] gap;
    logic [WeightW:0] mag;
    logic [WeightW+21:0] prod;
    logic [WeightW:0] q;
    logic signed [WeightW+1:0] sum;
    gap = $signed({2'b00, ceil}) - $signed({2'b00, cur});
    mag = gap[WeightW+1] ? (WeightW+1)'(-gap) : gap[WeightW:0];
    // reciprocal of fifty, exact for a 15-bit magnitude
    prod = {6'd0, mag} * 22'd1342178;
    q = (WeightW+1)'(prod >> 26);
    sum = gap[WeightW+1] ? $signed({2'b00, cur}) - $signed({1'b0, q})
                         : $signed({2'b00, cur}) + $signed({1'b0, q});
    return sum[WeightW-1:0];
  endfunction

endpackage

FILE: design/ccmt_ram.sv
// generic single port ram with registered read
module ccmt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: design/ccmt_front.sv
// front end: history tracking and job queue
module ccmt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [7:0]      text_byte,
  input  logic            starts_text,
  input  logic            pop,
  output logic            busy,
  output logic            job_valid,
  output ccmt_pkg::job_t  job
);
  import ccmt_pkg::*;

  logic [8*MaxContext-1:0] history;
  logic [LenW-1:0] count;
  job_t queue [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueuePtrW:0] fill;
  logic accept;
  job_t incoming;

  assign busy = (fill == (QueuePtrW+1)'(QueueDepth));
  assign accept = start && !busy;
  assign job_valid = (fill != '0);
  assign job = queue[rd_ptr];

  always_comb begin
    incoming.text_byte = text_byte;
    incoming.history = history;
    incoming.depth = starts_text ? '0 : count;
  end

  always_ff @(posedge clk) begin
    if (accept) queue[wr_ptr] <= incoming;
    if (rst) begin
      history <= '0;
      count <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (accept) begin
        history <= {history[8*MaxContext-9:0], text_byte};
        count <= (incoming.depth < LenW'(MaxContext)) ? incoming.depth + 1'b1
                                                     : incoming.depth;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && job_valid) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QueuePtrW+1)'(accept) - (QueuePtrW+1)'(pop && job_valid);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) pop |-> job_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) accept && starts_text |=> count == 1)
    else $error("history not restarted");
endmodule

FILE: design/ccmt_back.sv
// back end: sequential table search and update per context length
module ccmt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  ccmt_pkg::job_t              job,
  input  logic [ccmt_pkg::WeightW-1:0] ceiling,
  output logic                        pop,
  output ccmt_pkg::report_t           report
);
  import ccmt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CHECK = 5'b00100,
    S_NEXT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  job_t cur;
  logic [LenW-1:0] len;
  logic [CountW-1:0] used;
  logic [CountW-1:0] scan;
  logic [2:0] created, dropped;
  logic [WeightW-1:0] w [4];
  key_t key;
  logic we;
  logic [AddrW-1:0] addr;
  logic [EntryW-1:0] wdata, rdata;
  logic hit;
  logic [WeightW-1:0] upd;

  ccmt_ram #(.Width(EntryW), .Depth(TableEntries)) u_table (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign key = make_key(len, cur.history, cur.text_byte);
  assign hit = (rdata[EntryW-1 -: KeyW] == key);
  assign upd = smooth(rdata[WeightW-1:0], ceiling);
  assign pop = (state == S_IDLE) && job_valid;

  always_comb begin
    we = 1'b0;
    addr = scan[AddrW-1:0];
    wdata = {key, upd};
    if (state == S_CHECK && hit) we = 1'b1;
    if (state == S_NEXT && used < CountW'(TableEntries)) begin
      we = 1'b1;
      addr = used[AddrW-1:0];
      wdata = {key, NewWeight};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= job;
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      report <= '0;
      len <= '0;
      scan <= '0;
      created <= '0;
      dropped <= '0;
      for (int i = 0; i < 4; i++) w[i] <= '0;
    end else begin
      report.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            len <= LenW'(1);
            scan <= '0;
            created <= '0;
            dropped <= '0;
            for (int i = 0; i < 4; i++) w[i] <= '0;
            state <= (job.depth == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          state <= (scan < used) ? S_CHECK : S_NEXT;
        end
        S_CHECK: begin
          if (hit) begin
            if (len <= LenW'(4)) w[len[1:0] - 2'd1] <= upd;
            if (len >= cur.depth) state <= S_DONE;
            else begin
              len <= len + 1'b1;
              scan <= '0;
              state <= S_READ;
            end
          end else begin
            scan <= scan + 1'b1;
            state <= S_READ;
          end
        end
        S_NEXT: begin
          if (used < CountW'(TableEntries)) begin
            used <= used + 1'b1;
            created <= created + 1'b1;
            if (len <= LenW'(4)) w[len[1:0] - 2'd1] <= NewWeight;
          end else begin
            dropped <= dropped + 1'b1;
          end
          if (len >= cur.depth) state <= S_DONE;
          else begin
            len <= len + 1'b1;
            scan <= '0;
            state <= S_READ;
          end
        end
        S_DONE: begin
          report.valid <= 1'b1;
          report.created <= created;
          report.dropped <= dropped;
          report.entries <= used;
          report.weights <= {w[3], w[2], w[1], w[0]};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) used <= CountW'(TableEntries))
    else $error("table count beyond capacity");
  assert property (@(posedge clk) disable iff (rst) report.valid |-> $past(state) == S_DONE)
    else $error("report without completion");
  assert property (@(posedge clk) disable iff (rst) we |-> state == S_CHECK || state == S_NEXT)
    else $error("stray table write");
endmodule

FILE: design/char_context_model_trainer.sv
// top level of the character context model trainer
// Each byte is taken with start while busy is low and gives exactly one result on the
// result ports, marked by done for one cycle; the receiver cannot stall it. Each
// context length scans the pair table entry by entry on the single table memory
// port, reading each entry and then checking its key, so a byte takes longer as
// the table fills. A two-entry job queue lets the next bytes be taken while one
// is worked on. The table needs no clearing pass after reset: an entry count
// bounds the search.
module char_context_model_trainer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    text_byte,
  input  logic                          starts_text,
  input  logic                          cfg_we,
  input  logic [ccmt_pkg::WeightW-1:0]  cfg_data,
  output logic                          done,
  output logic [2:0]                    pairs_created,
  output logic [2:0]                    pairs_dropped,
  output logic [12:0]                   entries_in_use,
  output logic [ccmt_pkg::WeightW-1:0]  weight_ctx1,
  output logic [ccmt_pkg::WeightW-1:0]  weight_ctx2,
  output logic [ccmt_pkg::WeightW-1:0]  weight_ctx3,
  output logic [ccmt_pkg::WeightW-1:0]  weight_ctx4
);
  import ccmt_pkg::*;

  logic [WeightW-1:0] weight_ceiling;
  logic job_valid, pop;
  job_t job;
  report_t report;

  always_ff @(posedge clk) begin
    if (rst) weight_ceiling <= CeilingReset;
    else if (cfg_we) weight_ceiling <= cfg_data;
  end

  ccmt_front u_front (
    .clk(clk), .rst(rst), .start(start), .text_byte(text_byte),
    .starts_text(starts_text), .pop(pop), .busy(busy),
    .job_valid(job_valid), .job(job)
  );

  ccmt_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job),
    .ceiling(weight_ceiling), .pop(pop), .report(report)
  );

  assign done = report.valid;
  assign pairs_created = report.created;
  assign pairs_dropped = report.dropped;
  assign entries_in_use = report.entries[12:0];
  assign weight_ctx1 = report.weights[WeightW-1:0];
  assign weight_ctx2 = report.weights[2*WeightW-1:WeightW];
  assign weight_ctx3 = report.weights[3*WeightW-1:2*WeightW];
  assign weight_ctx4 = report.weights[4*WeightW-1:3*WeightW];
endmodule
